>>> src/necir_pkg.sv
// shared types, constants and key table of the nec infrared frame decoder
// no dependencies; imported by every module of the block

package necir_pkg;

	localparam int DATA_BITS = 32;
	localparam int BIT_W = $clog2(DATA_BITS);
	localparam int TICK_W = 15;
	localparam int MAX_SYMBOLS_DEF = 64;
	localparam int MIN_SYMBOLS_DEF = 33;

	localparam int CFG_IDX_W = 2;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 48;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_SPACE_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPACE_MIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE_MIN = 2'd3;

	localparam logic [TICK_W-1:0] HEADER_MARK_MIN_RST = 15'd8000;
	localparam logic [TICK_W-1:0] DATA_SPACE_MIN_RST = 15'd4000;
	localparam logic [TICK_W-1:0] REPEAT_SPACE_MIN_RST = 15'd2000;
	localparam logic [TICK_W-1:0] ONE_SPACE_MIN_RST = 15'd1000;

	// header classes
	localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
	localparam logic [1:0] CLASS_DATA = 2'd1;
	localparam logic [1:0] CLASS_REPEAT = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_DATA = 2'd0;
	localparam logic [1:0] STATUS_REPEAT = 2'd1;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

	localparam int KEY_COUNT = 17;
	localparam logic [15:0] KEY_CODES [KEY_COUNT] = '{
		16'hBA45, 16'hB946, 16'hB847, 16'hBB44, 16'hBF40, 16'hBC43, 16'hF807,
		16'hEA15, 16'hF609, 16'hE916, 16'hE619, 16'hF20D, 16'hE718, 16'hF708,
		16'hE31C, 16'hA55A, 16'hAD52
	};
	// '1'..'9', '*', '0', '#', 'U', 'L', 'O', 'R', 'D'
	localparam logic [6:0] KEY_CHARS [KEY_COUNT] = '{
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
		7'h2A, 7'h30, 7'h23, 7'h55, 7'h4C, 7'h4F, 7'h52, 7'h44
	};

	typedef struct packed {
		logic found;
		logic [6:0] code;
	} key_hit_t;

	// finished frame handed from the frame tracker to the result stage
	typedef struct packed {
		logic valid;
		logic [1:0] status;
		logic [DATA_BITS-1:0] word;
	} frame_res_t;

	function automatic key_hit_t key_lookup(input logic [15:0] upper);
		key_hit_t hit;
		hit.found = 1'b0;
		hit.code = '0;
		// table codes are distinct, so at most one entry matches
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (KEY_CODES[k] == upper) begin
				hit.found = 1'b1;
				hit.code = KEY_CHARS[k];
			end
		end
		return hit;
	endfunction

endpackage

>>> src/nec_ir_frame_decoder.sv
// nec infrared frame decoder: one pulse symbol per cycle in while no result is held,
// one result out per frame of at least MIN_SYMBOLS symbols; the frame end symbol
// goes to the input register, then its result to the output register
// a result held by m_tready low also holds the next symbol in the input register
// arst_n clears the frame state, both handshakes and the thresholds to their defaults
// depends on necir_pkg, necir_frame and necir_result

module nec_ir_frame_decoder
	import necir_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int MIN_SYMBOLS = MIN_SYMBOLS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // mark_ticks[14:0], space_ticks[29:15], zero pad
	input  logic s_tlast,                  // frame_end
	output logic m_tvalid,
	input  logic m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // data_word[31:0], command[39:32],
	                                       // key_found[40], key_char[47:41]
	output logic [1:0] m_tuser             // status
);

	frame_res_t res;
	logic sink_free;

	necir_frame #(
		.MAX_SYMBOLS(MAX_SYMBOLS),
		.MIN_SYMBOLS(MIN_SYMBOLS)
	) u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.sink_free(sink_free),
		.res(res)
	);

	necir_result u_result (
		.clk(clk),
		.arst_n(arst_n),
		.res(res),
		.sink_free(sink_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

endmodule

>>> src/necir_frame.sv
// input register, threshold registers and per-frame symbol tracking
// depends on necir_pkg

module necir_frame
	import necir_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int MIN_SYMBOLS = MIN_SYMBOLS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic s_tlast,
	input  logic sink_free,
	output frame_res_t res
);

	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

	logic valid_s1;
	logic [TICK_W-1:0] mark_s1;
	logic [TICK_W-1:0] space_s1;
	logic last_s1;

	logic [TICK_W-1:0] header_mark_min_q;
	logic [TICK_W-1:0] data_space_min_q;
	logic [TICK_W-1:0] repeat_space_min_q;
	logic [TICK_W-1:0] one_space_min_q;

	logic [CNT_W-1:0] count_q;
	logic [DATA_BITS-1:0] word_q;
	logic [1:0] class_q;

	logic advance;
	logic [CNT_W-1:0] count_nxt;
	logic [DATA_BITS-1:0] word_nxt;
	logic [1:0] class_nxt;
	logic [BIT_W-1:0] bit_idx;
	logic [CNT_W-1:0] count_dec;

	assign advance = valid_s1 && sink_free;
	assign s_tready = !valid_s1 || sink_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mark_s1 <= s_tdata[TICK_W-1:0];
			space_s1 <= s_tdata[2*TICK_W-1:TICK_W];
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_mark_min_q <= HEADER_MARK_MIN_RST;
			data_space_min_q <= DATA_SPACE_MIN_RST;
			repeat_space_min_q <= REPEAT_SPACE_MIN_RST;
			one_space_min_q <= ONE_SPACE_MIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER_MARK_MIN: header_mark_min_q <= cfg_data;
				REG_DATA_SPACE_MIN: data_space_min_q <= cfg_data;
				REG_REPEAT_SPACE_MIN: repeat_space_min_q <= cfg_data;
				REG_ONE_SPACE_MIN: one_space_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign count_dec = count_q - CNT_W'(1);
	assign bit_idx = count_dec[BIT_W-1:0];

	always_comb begin
		count_nxt = (count_q < CNT_W'(MAX_SYMBOLS)) ? count_q + CNT_W'(1) : count_q;
		class_nxt = class_q;
		word_nxt = word_q;
		if (count_q == '0) begin
			if (mark_s1 > header_mark_min_q && space_s1 > data_space_min_q) begin
				class_nxt = CLASS_DATA;
			end else if (mark_s1 > header_mark_min_q && space_s1 > repeat_space_min_q) begin
				class_nxt = CLASS_REPEAT;
			end else begin
				class_nxt = CLASS_UNKNOWN;
			end
		end else if (count_q <= CNT_W'(DATA_BITS)) begin
			if (space_s1 > one_space_min_q) begin
				word_nxt = word_q | (DATA_BITS'(1) << bit_idx);
			end
		end
	end

	always_comb begin
		res.valid = advance && last_s1 && (count_nxt >= CNT_W'(MIN_SYMBOLS));
		unique case (class_nxt)
			CLASS_DATA: res.status = STATUS_DATA;
			CLASS_REPEAT: res.status = STATUS_REPEAT;
			default: res.status = STATUS_UNKNOWN;
		endcase
		res.word = (class_nxt == CLASS_DATA) ? word_nxt : '0;
	end

	// frame end always returns the tracker to its cleared state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			word_q <= '0;
			class_q <= CLASS_UNKNOWN;
		end else if (advance) begin
			if (last_s1) begin
				count_q <= '0;
				word_q <= '0;
				class_q <= CLASS_UNKNOWN;
			end else begin
				count_q <= count_nxt;
				word_q <= word_nxt;
				class_q <= class_nxt;
			end
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SYMBOLS))
		else $error("symbol count above saturation limit");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (count_q == '0 && word_q == '0 && class_q == CLASS_UNKNOWN))
		else $error("frame state not cleared after frame end");

	a_result_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (last_s1 && valid_s1))
		else $error("result raised without a frame end symbol");

	a_word_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CNT_W'(1)) |-> (word_q == '0))
		else $error("data bits set before any bit symbol");

endmodule

>>> src/necir_result.sv
// key table lookup and output register of the decoded frame result
// depends on necir_pkg

module necir_result
	import necir_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  frame_res_t res,
	output logic sink_free,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [1:0] m_tuser
);

	logic out_valid_q;
	logic [1:0] status_q;
	logic [DATA_BITS-1:0] word_q;
	logic key_found_q;
	logic [6:0] key_char_q;
	key_hit_t hit;
	logic is_data;

	assign sink_free = !out_valid_q || m_tready;
	assign is_data = (res.status == STATUS_DATA);
	assign hit = key_lookup(res.word[DATA_BITS-1:DATA_BITS-16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q <= res.status;
			word_q <= res.word;
			key_found_q <= is_data && hit.found;
			key_char_q <= is_data ? hit.code : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = status_q;
	assign m_tdata = {key_char_q, key_found_q, word_q[23:16], word_q};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> sink_free)
		else $error("pending result overwritten");

	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != STATUS_DATA) |-> (word_q == '0 && !key_found_q))
		else $error("non-data result carries payload");

	a_char_iff_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (key_found_q == (key_char_q != '0)))
		else $error("key character disagrees with key found flag");

endmodule
